// ----- src/csrmv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrmv_pkg
// Shared types and constants for the CSR sparse matrix-vector accumulator.
// ----------------------------------------------------------------------------
package csrmv_pkg;

    // Default depth of the vector store.
    localparam int unsigned VECTOR_DEPTH_DEF = 1024;

    // Field widths of the stream beats.
    localparam int unsigned INDEX_W  = 10;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned ROW_W    = 16;
    localparam int unsigned ACC_W    = 64;
    localparam int unsigned ACTION_W = 2;

    // Packed widths of the stream data buses, padded to whole bytes.
    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned M_TDATA_W = 48;

    // Item kinds carried in the input tuser. The remaining code is ignored.
    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD    = 2'd0,
        ACT_NONZERO = 2'd1,
        ACT_ROW_END = 2'd2
    } t_action;

endpackage

// ----- src/csr_sparse_matvec_accumulator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_sparse_matvec_accumulator
// Streams CSR rows through a Q16.16 multiply-accumulate and emits one rounded,
// saturated Q16.16 sum per row, reading vector entries from an on-chip store.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Beat fields (tdata / tuser)                 Accepted when
//  s_axis   in   index[9:0], value[41:10] / action[1:0]     tvalid && tready
//  m_axis   out  row_sum[31:0], row_number[47:32] / sat[0]   tvalid && tready
//
// One beat is taken per clock cycle while s_axis_tready is high. The pipeline
// is four registers deep: store read, multiply, accumulate, round. A row sum
// passes through the rounding register to m_axis. Only row-end beats can hold
// up the pipeline, and only while the rounding register is full and the
// output register is full and stalled; loads and nonzeros keep flowing past
// a waiting result otherwise. Reset is synchronous and active low; it clears
// the accumulator, the row counter and all valid flags. The vector store is
// not cleared.
module csr_sparse_matvec_accumulator #(
    parameter int unsigned VECTOR_DEPTH = csrmv_pkg::VECTOR_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Slave side.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: entry_index [9:0], entry_value [41:10], zero [47:42].
    input  logic [csrmv_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // tuser: action [1:0].
    input  logic [csrmv_pkg::ACTION_W-1:0]     s_axis_tuser,
    // Master side.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: row_sum [31:0], row_number [47:32].
    output logic [csrmv_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // tuser: saturated [0].
    output logic                               m_axis_tuser
);

    localparam int unsigned AddrW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

    // ------------------------------------------------------------------------
    // Input beat decode.
    // ------------------------------------------------------------------------
    logic                                   w_in_accept;
    csrmv_pkg::t_action                     w_in_action;
    logic [csrmv_pkg::INDEX_W-1:0]          w_in_index;
    logic [csrmv_pkg::VALUE_W-1:0]          w_in_value;
    logic [AddrW-1:0]                       w_in_addr;
    logic                                   w_in_range;

    assign w_in_action = csrmv_pkg::t_action'(s_axis_tuser);
    assign w_in_index  = s_axis_tdata[csrmv_pkg::INDEX_W-1:0];
    assign w_in_value  = s_axis_tdata[csrmv_pkg::INDEX_W +: csrmv_pkg::VALUE_W];
    assign w_in_addr   = AddrW'(w_in_index);
    // Indexes past the store are dropped by loads and add nothing for nonzeros.
    assign w_in_range  = 32'(w_in_index) < 32'(VECTOR_DEPTH);

    // ------------------------------------------------------------------------
    // Pipeline registers.
    // ------------------------------------------------------------------------
    // Stage 1: registered store read.
    logic                                   r_s1_valid;
    csrmv_pkg::t_action                     r_s1_action;
    logic                                   r_s1_range;
    logic signed [csrmv_pkg::VALUE_W-1:0]   r_s1_value;
    logic signed [csrmv_pkg::VALUE_W-1:0]   r_s1_rdata;
    // Stage 2: Q32.32 product.
    logic                                   r_s2_valid;
    csrmv_pkg::t_action                     r_s2_action;
    logic                                   r_s2_range;
    logic signed [csrmv_pkg::ACC_W-1:0]     r_s2_prod;
    // Row accumulator state.
    logic signed [csrmv_pkg::ACC_W-1:0]     r_acc;
    logic                                   r_acc_ovf;
    logic [csrmv_pkg::ROW_W-1:0]            r_row_cnt;
    // Finished row waiting for rounding.
    logic                                   r_rnd_valid;
    logic signed [csrmv_pkg::ACC_W-1:0]     r_rnd_acc;
    logic                                   r_rnd_ovf;
    logic [csrmv_pkg::ROW_W-1:0]            r_rnd_row;
    // Output register.
    logic                                   r_out_valid;
    logic [csrmv_pkg::VALUE_W-1:0]          r_out_sum;
    logic [csrmv_pkg::ROW_W-1:0]            r_out_row;
    logic                                   r_out_sat;

    // Vector store: local entries first, halo entries after them.
    logic [csrmv_pkg::VALUE_W-1:0]          r_store [VECTOR_DEPTH];

    // ------------------------------------------------------------------------
    // Flow control. Each stage moves when the next one is free or moving.
    // Only a row-end beat in stage 2 needs the rounding register.
    // ------------------------------------------------------------------------
    logic w_out_free;
    logic w_rnd_move;
    logic w_rnd_free;
    logic w_s2_fire;
    logic w_s2_free;
    logic w_s1_load;

    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign w_rnd_move  = r_rnd_valid && w_out_free;
    assign w_rnd_free  = !r_rnd_valid || w_out_free;
    assign w_s2_fire   = r_s2_valid &&
                         ((r_s2_action != csrmv_pkg::ACT_ROW_END) || w_rnd_free);
    assign w_s2_free   = !r_s2_valid || w_s2_fire;
    assign w_s1_load   = !r_s1_valid || w_s2_free;

    assign s_axis_tready = w_s1_load;
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------------
    // Vector store: write on a load beat, read for every beat entering stage 1.
    // A load is written at its own accept edge, so the next beat reads it.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_in_accept && (w_in_action == csrmv_pkg::ACT_LOAD) && w_in_range) begin
            r_store[w_in_addr] <= w_in_value;
        end
        if (w_s1_load) begin
            r_s1_rdata <= r_store[w_in_addr];
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1 and stage 2.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_s1_load) begin
                r_s1_valid <= w_in_accept;
            end
            if (w_s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_load) begin
            r_s1_action <= w_in_action;
            r_s1_range  <= w_in_range;
            r_s1_value  <= w_in_value;
        end
        if (w_s2_free) begin
            r_s2_action <= r_s1_action;
            r_s2_range  <= r_s1_range;
            // Both operands are signed, so the 64-bit product is exact Q32.32.
            r_s2_prod   <= r_s1_value * r_s1_rdata;
        end
    end

    // ------------------------------------------------------------------------
    // Saturating accumulate. The sum is formed one bit wider; a carry into
    // the extra bit that disagrees with the top bit marks an overflow.
    // ------------------------------------------------------------------------
    logic signed [csrmv_pkg::ACC_W:0]       w_sum_wide;
    logic                                   w_sum_ovf;
    logic signed [csrmv_pkg::ACC_W-1:0]     w_sum_sat;

    assign w_sum_wide = {r_acc[csrmv_pkg::ACC_W-1], r_acc}
                      + {r_s2_prod[csrmv_pkg::ACC_W-1], r_s2_prod};
    assign w_sum_ovf  = w_sum_wide[csrmv_pkg::ACC_W] != w_sum_wide[csrmv_pkg::ACC_W-1];

    always_comb begin
        if (!w_sum_ovf) begin
            w_sum_sat = w_sum_wide[csrmv_pkg::ACC_W-1:0];
        end else if (w_sum_wide[csrmv_pkg::ACC_W]) begin
            w_sum_sat = {1'b1, {(csrmv_pkg::ACC_W-1){1'b0}}};
        end else begin
            w_sum_sat = {1'b0, {(csrmv_pkg::ACC_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_acc_ovf <= 1'b0;
            r_row_cnt <= '0;
        end else if (w_s2_fire) begin
            case (r_s2_action)
                csrmv_pkg::ACT_NONZERO: begin
                    if (r_s2_range) begin
                        r_acc     <= w_sum_sat;
                        r_acc_ovf <= r_acc_ovf | w_sum_ovf;
                    end
                end
                csrmv_pkg::ACT_ROW_END: begin
                    r_acc     <= '0;
                    r_acc_ovf <= 1'b0;
                    r_row_cnt <= r_row_cnt + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Finished row snapshot.
    // ------------------------------------------------------------------------
    logic w_row_done;

    assign w_row_done = w_s2_fire && (r_s2_action == csrmv_pkg::ACT_ROW_END);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rnd_valid <= 1'b0;
        end else if (w_row_done) begin
            r_rnd_valid <= 1'b1;
        end else if (w_rnd_move) begin
            r_rnd_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_row_done) begin
            r_rnd_acc <= r_acc;
            r_rnd_ovf <= r_acc_ovf;
            r_rnd_row <= r_row_cnt;
        end
    end

    // ------------------------------------------------------------------------
    // Round half up to Q16.16, then clamp to 32 bits.
    // ------------------------------------------------------------------------
    localparam int unsigned QuotW = csrmv_pkg::ACC_W + 1 - 16;

    logic signed [csrmv_pkg::ACC_W:0]       w_rnd_wide;
    logic signed [QuotW-1:0]                w_quot;
    logic                                   w_clamp;
    logic [csrmv_pkg::VALUE_W-1:0]          w_rnd_sum;

    assign w_rnd_wide = {r_rnd_acc[csrmv_pkg::ACC_W-1], r_rnd_acc}
                      + (csrmv_pkg::ACC_W + 1)'(32768);
    assign w_quot     = w_rnd_wide[csrmv_pkg::ACC_W:16];
    // The quotient fits in 32 bits only if its top bits all match bit 31.
    assign w_clamp    = !((&w_quot[QuotW-1:csrmv_pkg::VALUE_W-1]) ||
                          !(|w_quot[QuotW-1:csrmv_pkg::VALUE_W-1]));

    always_comb begin
        if (!w_clamp) begin
            w_rnd_sum = w_quot[csrmv_pkg::VALUE_W-1:0];
        end else if (w_quot[QuotW-1]) begin
            w_rnd_sum = {1'b1, {(csrmv_pkg::VALUE_W-1){1'b0}}};
        end else begin
            w_rnd_sum = {1'b0, {(csrmv_pkg::VALUE_W-1){1'b1}}};
        end
    end

    // ------------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_rnd_move) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rnd_move) begin
            r_out_sum <= w_rnd_sum;
            r_out_row <= r_rnd_row;
            r_out_sat <= r_rnd_ovf | w_clamp;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_row, r_out_sum};
    assign m_axis_tuser  = r_out_sat;

endmodule

// ----- src/csrmv_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrmv_checker
// Port-level checks for the CSR sparse matrix-vector accumulator.
// ----------------------------------------------------------------------------
module csrmv_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic [csrmv_pkg::ACTION_W-1:0]     s_axis_tuser,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [csrmv_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input  logic                               m_axis_tuser
);

    logic                                   w_in_row_end;
    logic                                   w_out_beat;
    logic [7:0]                             r_pending;
    logic [csrmv_pkg::ROW_W-1:0]            r_next_row;

    assign w_in_row_end = s_axis_tvalid && s_axis_tready &&
                          (s_axis_tuser == csrmv_pkg::ACT_ROW_END);
    assign w_out_beat   = m_axis_tvalid && m_axis_tready;

    // Row ends taken but whose sums are not yet delivered, and the row number
    // that the next delivered sum must carry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending  <= '0;
            r_next_row <= '0;
        end else begin
            r_pending <= r_pending + 8'(w_in_row_end) - 8'(w_out_beat);
            if (w_out_beat) begin
                r_next_row <= r_next_row + 1'b1;
            end
        end
    end

    // Every delivered sum answers an earlier row-end beat.
    a_no_invented_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_beat |-> r_pending != 8'd0)
        else $error("result delivered without a pending row end");

    // Row numbers come out in order with no gaps.
    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_beat |-> m_axis_tdata[47:32] == r_next_row)
        else $error("row number out of sequence");

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Nothing is offered in the first cycle out of reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result offered right after reset");

endmodule

bind csr_sparse_matvec_accumulator csrmv_checker u_csrmv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- test/csr_sparse_matvec_accumulator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_sparse_matvec_accumulator_tb
// Self-checking bench for the CSR row accumulator: streams vector loads, matrix
// nonzeros and row ends into the block, predicts every Q16.16 row sum in a
// bit-true software image of the datapath and compares each output beat.
// ----------------------------------------------------------------------------
//
// The bench is built from three clocked processes and one sequencer:
//   - the stimulus driver (falling edge) pops items from a pending queue and
//     offers them on s_axis, holding each beat until it is taken;
//   - the sink (falling edge) drives m_axis_tready with random stalls and, on
//     request, one long hold-off so the pipeline backs up into s_axis;
//   - the monitor (rising edge) samples both handshakes, feeds every accepted
//     input beat to the row-sum predictor and checks every output beat
//     against the oldest predicted row sum. It also runs the watchdog;
//   - the initial block fills the pending queue phase by phase and picks the
//     idle and stall rates of each phase.
//
// Nonzeros only ever address vector entries that were loaded earlier in the
// stream, since reading an unwritten entry is undefined for the block.
//
module csr_sparse_matvec_accumulator_tb;

    // The spare action code: the block drops these beats without a result.
    localparam logic [csrmv_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

    localparam int unsigned STORE_DEPTH          = csrmv_pkg::VECTOR_DEPTH_DEF;
    // Long enough to fill all four pipeline registers and block a row end.
    localparam int unsigned PRESSURE_HOLD_CYCLES = 400;
    // Cycles without any beat on either side before the run is abandoned.
    // The worst legal gap is the pressure hold-off plus a few random stalls.
    localparam int unsigned WATCHDOG_LIMIT       = 4000;
    localparam int unsigned RANDOM_ITEMS_PER_PHASE = 250;
    localparam int unsigned MAX_REPORTS          = 50;
    localparam int unsigned DRAIN_CYCLES         = 8;

    typedef struct packed {
        logic [csrmv_pkg::ACTION_W-1:0] action;
        logic [csrmv_pkg::INDEX_W-1:0]  index;
        logic [csrmv_pkg::VALUE_W-1:0]  value;
    } t_stream_item;

    typedef struct packed {
        logic [csrmv_pkg::VALUE_W-1:0] row_sum;
        logic [csrmv_pkg::ROW_W-1:0]   row_number;
        logic                          sat;
    } t_row_result;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT ports. Every input has a known value from time 0.
    // ------------------------------------------------------------------------
    logic                             i_clk         = 1'b0;
    logic                             i_rst_n       = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    // tdata: entry_index [9:0], entry_value [41:10], zero [47:42].
    logic [csrmv_pkg::S_TDATA_W-1:0]  s_axis_tdata  = '0;
    // tuser: action [1:0].
    logic [csrmv_pkg::ACTION_W-1:0]   s_axis_tuser  = csrmv_pkg::ACT_LOAD;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    // tdata: row_sum [31:0], row_number [47:32].
    logic [csrmv_pkg::M_TDATA_W-1:0]  m_axis_tdata;
    // tuser: saturated [0].
    logic                             m_axis_tuser;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    csr_sparse_matvec_accumulator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // ------------------------------------------------------------------------
    // Shared bench state.
    // ------------------------------------------------------------------------
    t_stream_item    pending_items[$];
    t_row_result     row_sums_due[$];

    int unsigned     send_idle_pct  = 0;
    int unsigned     recv_stall_pct = 0;
    int unsigned     holds_asked    = 0;   // written by the sequencer only
    int unsigned     holds_served   = 0;   // written by the sink only
    int unsigned     hold_left      = 0;

    bit              in_taken       = 1'b0;
    bit              out_taken      = 1'b0;
    int unsigned     quiet_cycles   = 0;

    int unsigned     mismatches     = 0;
    int unsigned     beats_in       = 0;
    int unsigned     rows_checked   = 0;
    int unsigned     sat_rows       = 0;

    // Which vector entries the stimulus has loaded so far.
    bit              entry_loaded[STORE_DEPTH];
    int unsigned     loaded_indices[$];

    // Software image of the datapath state.
    logic signed [csrmv_pkg::VALUE_W-1:0] vector_image[STORE_DEPTH];
    logic signed [csrmv_pkg::ACC_W-1:0]   row_acc   = '0;
    logic                                 row_sat   = 1'b0;
    logic [csrmv_pkg::ROW_W-1:0]          row_count = '0;

    // ------------------------------------------------------------------------
    // Mismatch reporting: one line per failure, printing capped so a badly
    // broken block cannot flood the log.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [csrmv_pkg::M_TDATA_W-1:0] got,
                                   logic [csrmv_pkg::M_TDATA_W-1:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] row result mismatch: %s got %0h expected %0h",
                     $time, what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // Row-sum predictor. Products of two Q16.16 values are exact Q32.32 values,
    // summed with a saturating 64-bit add. A row end rounds half up to Q16.16
    // and clamps to 32 bits; any saturation in the row raises the flag.
    // ------------------------------------------------------------------------
    task automatic predict_row_item(logic [csrmv_pkg::ACTION_W-1:0] act,
                                    logic [csrmv_pkg::INDEX_W-1:0] idx,
                                    logic signed [csrmv_pkg::VALUE_W-1:0] val);
        logic signed [csrmv_pkg::ACC_W-1:0] prod;
        logic signed [csrmv_pkg::ACC_W-1:0] total;
        logic signed [csrmv_pkg::ACC_W:0]   biased;
        logic signed [48:0]                 quot;
        t_row_result                        res;
        case (act)
            csrmv_pkg::ACT_LOAD: begin
                if (idx < STORE_DEPTH)
                    vector_image[idx] = val;
            end
            csrmv_pkg::ACT_NONZERO: begin
                if (idx < STORE_DEPTH) begin
                    prod  = val * vector_image[idx];
                    total = row_acc + prod;
                    // Overflow only when both terms share a sign the sum lost.
                    if (row_acc[csrmv_pkg::ACC_W-1] == prod[csrmv_pkg::ACC_W-1] &&
                        total[csrmv_pkg::ACC_W-1] != row_acc[csrmv_pkg::ACC_W-1]) begin
                        row_sat = 1'b1;
                        total   = row_acc[csrmv_pkg::ACC_W-1]
                                ? {1'b1, {(csrmv_pkg::ACC_W-1){1'b0}}}
                                : {1'b0, {(csrmv_pkg::ACC_W-1){1'b1}}};
                    end
                    row_acc = total;
                end
            end
            csrmv_pkg::ACT_ROW_END: begin
                // One extra bit keeps the rounding bias from wrapping.
                biased = {row_acc[csrmv_pkg::ACC_W-1], row_acc} + 65'sd32768;
                quot   = biased >>> 16;
                res.sat = row_sat;
                if (quot > 49'sd2147483647) begin
                    res.row_sum = 32'h7FFF_FFFF;
                    res.sat     = 1'b1;
                end else if (quot < -49'sd2147483648) begin
                    res.row_sum = 32'h8000_0000;
                    res.sat     = 1'b1;
                end else begin
                    res.row_sum = quot[csrmv_pkg::VALUE_W-1:0];
                end
                res.row_number = row_count;
                row_sums_due.insert(row_sums_due.size(), res);
                row_acc   = '0;
                row_sat   = 1'b0;
                row_count = row_count + 1'b1;
            end
            default: begin
                // The spare code leaves every piece of state alone.
            end
        endcase
    endtask

    task automatic check_row_result();
        t_row_result want;
        if (row_sums_due.size() == 0) begin
            report_mismatch("row sum with none pending", m_axis_tdata, '0);
            return;
        end
        want = row_sums_due.pop_front();
        if (m_axis_tdata[31:0] !== want.row_sum)
            report_mismatch("row_sum", {16'h0, m_axis_tdata[31:0]},
                            {16'h0, want.row_sum});
        if (m_axis_tdata[47:32] !== want.row_number)
            report_mismatch("row_number", {32'h0, m_axis_tdata[47:32]},
                            {32'h0, want.row_number});
        if (m_axis_tuser !== want.sat)
            report_mismatch("saturated", {47'h0, m_axis_tuser}, {47'h0, want.sat});
        rows_checked++;
        if (want.sat)
            sat_rows++;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic queue_item(logic [csrmv_pkg::ACTION_W-1:0] act, int unsigned idx,
                              logic [csrmv_pkg::VALUE_W-1:0] val);
        t_stream_item item;
        item.action = act;
        item.index  = idx[csrmv_pkg::INDEX_W-1:0];
        item.value  = val;
        if (act == csrmv_pkg::ACT_LOAD && !entry_loaded[idx]) begin
            entry_loaded[idx] = 1'b1;
            loaded_indices.insert(loaded_indices.size(), idx);
        end
        pending_items.insert(pending_items.size(), item);
    endtask

    // Mix of full-range words, modest signed values around a few units, and
    // the corner words that drive saturation and rounding.
    function automatic logic [csrmv_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($urandom_range(0, 32'h0007_FFFF)) - 32'h0004_0000;
            2: begin
                case ($urandom_range(0, 4))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'hFFFF_FFFF;
                    3: return 32'h0001_0000;
                    default: return 32'h0000_0000;
                endcase
            end
            default: return 32'($urandom_range(0, 32'h0000_FFFF)) - 32'h0000_8000;
        endcase
    endfunction

    function automatic int unsigned pick_loaded_index();
        return loaded_indices[$urandom_range(0, loaded_indices.size() - 1)];
    endfunction

    // Mostly complete rows on loaded entries, with load bursts, vector updates
    // inside rows and spare-code beats as noise. Spare beats do not count.
    task automatic queue_random_traffic(int unsigned item_target);
        int unsigned queued;
        int unsigned burst;
        int unsigned k;
        queued = 0;
        while (queued < item_target) begin
            case ($urandom_range(0, 19))
                0, 1, 2: begin
                    burst = $urandom_range(1, 4);
                    for (k = 0; k < burst; k++)
                        queue_item(csrmv_pkg::ACT_LOAD, $urandom_range(0, STORE_DEPTH - 1),
                                   pick_value());
                    queued += burst;
                end
                3: begin
                    queue_item(ACT_UNUSED, $urandom_range(0, STORE_DEPTH - 1), $urandom());
                end
                default: begin
                    burst = $urandom_range(0, 6);
                    for (k = 0; k < burst; k++) begin
                        if ($urandom_range(0, 9) == 0) begin
                            queue_item(csrmv_pkg::ACT_LOAD,
                                       $urandom_range(0, STORE_DEPTH - 1), pick_value());
                            queued++;
                        end
                        queue_item(csrmv_pkg::ACT_NONZERO, pick_loaded_index(),
                                   pick_value());
                        queued++;
                    end
                    // Index and value of a row end are don't-care; randomize them.
                    queue_item(csrmv_pkg::ACT_ROW_END, $urandom_range(0, STORE_DEPTH - 1),
                               $urandom());
                    queued++;
                end
            endcase
        end
    endtask

    // Hand-picked opening: field extremes, every action, empty rows, both
    // rounding directions at the half step, saturation in the accumulator in
    // both directions and saturation of the output clamp alone.
    task automatic queue_directed_items();
        queue_item(csrmv_pkg::ACT_LOAD, 0, 32'h0001_8000);           // 1.5
        queue_item(csrmv_pkg::ACT_LOAD, STORE_DEPTH - 1, 32'h8000_0000);
        queue_item(csrmv_pkg::ACT_LOAD, 1, 32'h7FFF_FFFF);
        queue_item(csrmv_pkg::ACT_LOAD, 2, 32'h0000_8000);           // 0.5
        queue_item(csrmv_pkg::ACT_LOAD, 3, 32'hFFFF_FFFF);
        queue_item(csrmv_pkg::ACT_ROW_END, 0, 32'h0000_0000);        // empty row gives zero
        queue_item(ACT_UNUSED, STORE_DEPTH - 1, 32'hFFFF_FFFF);
        // Exactly +half rounds up to one LSB.
        queue_item(csrmv_pkg::ACT_NONZERO, 2, 32'h0000_0001);
        queue_item(csrmv_pkg::ACT_ROW_END, STORE_DEPTH - 1, 32'hFFFF_FFFF);
        // Exactly -half rounds up to zero.
        queue_item(csrmv_pkg::ACT_NONZERO, 2, 32'hFFFF_FFFF);
        queue_item(csrmv_pkg::ACT_ROW_END, 0, 32'h0000_0000);
        // Just below -half rounds to minus one LSB.
        queue_item(csrmv_pkg::ACT_NONZERO, 2, 32'hFFFF_FFFF);
        queue_item(csrmv_pkg::ACT_NONZERO, 3, 32'h0000_0001);
        queue_item(csrmv_pkg::ACT_ROW_END, 0, 32'h0000_0000);
        // Three products of 2^62 run the accumulator into its positive limit.
        repeat (3) queue_item(csrmv_pkg::ACT_NONZERO, STORE_DEPTH - 1, 32'h8000_0000);
        queue_item(csrmv_pkg::ACT_ROW_END, 0, 32'h0000_0000);
        // Same toward the negative limit.
        repeat (3) queue_item(csrmv_pkg::ACT_NONZERO, 1, 32'h8000_0000);
        queue_item(csrmv_pkg::ACT_ROW_END, 0, 32'h0000_0000);
        // One large product: no accumulator overflow, but the output clamps.
        // A spare-code beat in mid-row must not disturb the sum.
        queue_item(csrmv_pkg::ACT_NONZERO, 1, 32'h7FFF_FFFF);
        queue_item(ACT_UNUSED, 0, 32'h0000_0000);
        queue_item(csrmv_pkg::ACT_ROW_END, 0, 32'h0000_0000);
        // A plain in-range row: 1.0 * 1.5.
        queue_item(csrmv_pkg::ACT_NONZERO, 0, 32'h0001_0000);
        queue_item(csrmv_pkg::ACT_ROW_END, 0, 32'h0000_0000);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus driver. A beat stays on the bus until it is taken; a new one is
    // offered, or the bus goes idle, only once the previous beat is gone.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_stream_item item;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                item = pending_items.pop_front();
                s_axis_tdata  <= {{(csrmv_pkg::S_TDATA_W - csrmv_pkg::INDEX_W
                                    - csrmv_pkg::VALUE_W){1'b0}},
                                  item.value, item.index};
                s_axis_tuser  <= item.action;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result sink. A hold-off request from the sequencer keeps tready low for
    // a fixed stretch, counted here, while the driver keeps offering beats.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (holds_served != holds_asked) begin
                holds_served++;
                hold_left = PRESSURE_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: samples both handshakes at the rising edge, predicts on input
    // beats, checks output beats, and runs the watchdog.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            in_taken  = s_axis_tvalid && s_axis_tready;
            out_taken = m_axis_tvalid && m_axis_tready;
            if (in_taken) begin
                beats_in++;
                predict_row_item(s_axis_tuser, s_axis_tdata[csrmv_pkg::INDEX_W-1:0],
                                 s_axis_tdata[csrmv_pkg::INDEX_W +: csrmv_pkg::VALUE_W]);
            end
            if (out_taken)
                check_row_result();
            if (in_taken || out_taken ||
                (pending_items.size() == 0 && !s_axis_tvalid && row_sums_due.size() == 0))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[%0t] watchdog: no beat moved for %0d cycles, %0d row sums pending",
                         $time, quiet_cycles, row_sums_due.size());
                $display("csr_sparse_matvec_accumulator_tb: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------------
    task automatic wait_until_drained();
        while (pending_items.size() != 0 || s_axis_tvalid || row_sums_due.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        t_row_result lost_row;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Phase 1: no idling anywhere. Directed items, then random rows.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_directed_items();
        queue_random_traffic(RANDOM_ITEMS_PER_PHASE);
        wait_until_drained();

        // Phase 2: sender mostly idle, sink always ready.
        send_idle_pct  = 81;
        recv_stall_pct = 0;
        queue_random_traffic(RANDOM_ITEMS_PER_PHASE);
        wait_until_drained();

        // Phase 3: a long sink hold-off against a busy sender backs the
        // pipeline up into s_axis, then the sink stalls most cycles.
        send_idle_pct  = 0;
        recv_stall_pct = 81;
        holds_asked++;
        queue_random_traffic(RANDOM_ITEMS_PER_PHASE);
        wait_until_drained();

        // Phase 4: light idling on both sides.
        send_idle_pct  = 8;
        recv_stall_pct = 8;
        queue_random_traffic(RANDOM_ITEMS_PER_PHASE);
        wait_until_drained();

        // Let the pipeline settle so a stray extra beat would still be seen.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (row_sums_due.size() != 0) begin
            lost_row = row_sums_due.pop_front();
            report_mismatch("row sum never produced", '0,
                            {lost_row.row_number, lost_row.row_sum});
        end

        $display("Run covered %0d input beats and %0d checked row sums, %0d of them saturated,",
                 beats_in, rows_checked, sat_rows);
        $display("rounding corners at the half step, saturation both ways and four idle/stall mixes.");
        if (mismatches == 0) begin
            $display("csr_sparse_matvec_accumulator_tb: PASS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("csr_sparse_matvec_accumulator_tb: FAIL");
        end
        $finish;
    end

endmodule
